FILE: design/vtp_pkg.sv
package vtp_pkg;

	typedef enum logic [3:0] {
		S_GROUND  = 4'd0,
		S_ESC     = 4'd1,
		S_ESCI    = 4'd2,
		S_CSIE    = 4'd3,
		S_CSIP    = 4'd4,
		S_CSII    = 4'd5,
		S_CSIX    = 4'd6,
		S_OSC     = 4'd7,
		S_DCSE    = 4'd8,
		S_DCSP    = 4'd9,
		S_DCSI    = 4'd10,
		S_DCSPASS = 4'd11,
		S_DCSX    = 4'd12,
		S_SOS     = 4'd13,
		S_UTF8    = 4'd14
	} pstate_t;

	typedef enum logic [1:0] {
		TP_NONE = 2'd0,
		TP_DCS  = 2'd1,
		TP_OSC  = 2'd2
	} tp_t;

	localparam logic [3:0] EV_PRINT    = 4'd0;
	localparam logic [3:0] EV_EXECUTE  = 4'd1;
	localparam logic [3:0] EV_PARAM    = 4'd2;
	localparam logic [3:0] EV_ESC      = 4'd3;
	localparam logic [3:0] EV_CSI      = 4'd4;
	localparam logic [3:0] EV_OSC_BYTE = 4'd5;
	localparam logic [3:0] EV_OSC_END  = 4'd6;
	localparam logic [3:0] EV_DCS_HOOK = 4'd7;
	localparam logic [3:0] EV_DCS_BYTE = 4'd8;
	localparam logic [3:0] EV_DCS_END  = 4'd9;
	localparam logic [3:0] EV_ABORT    = 4'd10;

	localparam logic [7:0] B_ESC = 8'h1B;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_SUB = 8'h1A;
	localparam logic [7:0] B_BEL = 8'h07;
	localparam logic [7:0] B_ST  = 8'h9C;
	localparam logic [7:0] B_CSI = 8'h9B;
	localparam logic [7:0] B_OSC = 8'h9D;
	localparam logic [7:0] B_DCS = 8'h90;
	localparam logic [7:0] B_DEL = 8'h7F;
	localparam logic [7:0] B_BSL = 8'h5C;

	localparam logic [15:0] NUM_MAX      = 16'd65535;
	localparam logic [20:0] STR_CAP_RST  = 21'd1048576;
	localparam logic [16:0] NONE_17      = 17'h1FFFF;

	typedef struct packed {
		pstate_t       ps;
		logic [15:0]   acc;
		logic          acc_st;
		logic          sub;
		logic [31:0]   inter;
		logic [2:0]    fill;
		logic [16:0]   osc;
		logic          osc_done;
		logic [20:0]   slen;
		logic [7:0]    dcs_final;
		tp_t           tp;
		logic          seq_em;
		logic [20:0]   u8acc;
		logic [1:0]    u8left;
	} vtp_state_t;

	typedef struct packed {
		logic [3:0]  ev;
		logic [20:0] ch;
		logic [16:0] pv;
		logic        sub;
		logic [31:0] inter;
		logic [2:0]  cnt;
		logic [16:0] osc;
		logic        last;
	} vtp_res_t;

endpackage

FILE: design/vtp_step.sv
module vtp_step #(
	parameter int InterCap = 4
) (
	input  vtp_pkg::vtp_state_t st,
	input  logic [7:0]          b,
	input  logic [20:0]         cap,
	output vtp_pkg::vtp_state_t nxt,
	output vtp_pkg::vtp_res_t   res0,
	output vtp_pkg::vtp_res_t   res1,
	output logic [1:0]          n
);
	import vtp_pkg::*;

	typedef struct packed {
		vtp_res_t   r0;
		vtp_res_t   r1;
		logic [1:0] n;
	} pair_t;

	function automatic vtp_res_t mk(logic [3:0] ev, logic [20:0] ch, logic [16:0] pv,
			logic sub, vtp_state_t s);
		vtp_res_t r;
		r = '0;
		r.ev = ev;
		r.ch = ch;
		r.pv = pv;
		r.sub = sub;
		if (ev == EV_ESC || ev == EV_CSI || ev == EV_DCS_HOOK) begin
			r.inter = s.inter;
			r.cnt = s.fill;
		end
		if (ev == EV_OSC_BYTE || ev == EV_OSC_END)
			r.osc = s.osc;
		return r;
	endfunction

	function automatic pair_t push(pair_t p, vtp_res_t x);
		pair_t q;
		q = p;
		if (p.n == 2'd0) begin
			q.r0 = x;
			q.n = 2'd1;
		end else if (p.n == 2'd1) begin
			q.r1 = x;
			q.n = 2'd2;
		end
		return q;
	endfunction

	function automatic vtp_state_t clr(vtp_state_t s);
		vtp_state_t t;
		t = s;
		t.acc = '0;
		t.acc_st = 1'b0;
		t.sub = 1'b0;
		t.inter = '0;
		t.fill = '0;
		t.osc = NONE_17;
		t.osc_done = 1'b0;
		t.slen = '0;
		t.dcs_final = '0;
		t.tp = TP_NONE;
		t.seq_em = 1'b0;
		return t;
	endfunction

	function automatic vtp_state_t coll(vtp_state_t s, logic [7:0] c);
		vtp_state_t t;
		t = s;
		if (s.fill < 3'(InterCap)) begin
			t.inter[8*s.fill[1:0] +: 8] = c;
			t.fill = s.fill + 3'd1;
		end
		return t;
	endfunction

	// value times ten plus digit, held at the 16-bit ceiling
	function automatic logic [15:0] dig(logic [15:0] v, logic [7:0] c);
		logic [19:0] w;
		w = {1'b0, v, 3'b0} + {3'b0, v, 1'b0} + {16'd0, c[3:0]};
		return (w > {4'd0, NUM_MAX}) ? NUM_MAX : w[15:0];
	endfunction

	vtp_state_t s;
	pair_t      o;
	logic       done;
	logic       is_dig;
	logic [16:0] pv;

	assign is_dig = (b >= 8'h30) && (b <= 8'h39);

	always_comb begin
		s = st;
		o = '0;
		done = 1'b0;
		pv = '0;

		if (s.ps == S_UTF8) begin
			if (b[7:6] == 2'b10) begin
				s.u8acc = {s.u8acc[14:0], b[5:0]};
				if (s.u8left != 2'd0)
					s.u8left = s.u8left - 2'd1;
				if (s.u8left == 2'd0) begin
					s.ps = S_GROUND;
					o = push(o, mk(EV_PRINT, s.u8acc, '0, 1'b0, s));
				end
				done = 1'b1;
			end else begin
				s.u8left = 2'd0;
				s.ps = S_GROUND;
			end
		end

		if (!done && b == B_ESC) begin
			if (s.ps == S_DCSPASS)
				s.tp = TP_DCS;
			else if (s.ps == S_OSC)
				s.tp = TP_OSC;
			else begin
				if (s.seq_em)
					o = push(o, mk(EV_ABORT, '0, '0, 1'b0, s));
				s = clr(s);
			end
			s.ps = S_ESC;
			done = 1'b1;
		end

		if (!done && (b == B_CAN || b == B_SUB)) begin
			if (s.seq_em)
				o = push(o, mk(EV_ABORT, '0, '0, 1'b0, s));
			s = clr(s);
			o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
			s.ps = S_GROUND;
			done = 1'b1;
		end

		if (!done) begin
			// parameter event value, used by every emit of a parameter below
			pv = s.acc_st ? {1'b0, s.acc} : NONE_17;
			unique case (s.ps)
				S_ESC: begin
					if (b != B_DEL) begin
						if (s.tp != TP_NONE && b == B_BSL) begin
							if (s.tp == TP_DCS)
								o = push(o, mk(EV_DCS_END, {13'd0, s.dcs_final}, '0, 1'b0, s));
							else
								o = push(o, mk(EV_OSC_END, {13'd0, b}, '0, 1'b0, s));
							s = clr(s);
							s.ps = S_GROUND;
						end else begin
							if (s.tp != TP_NONE) begin
								if (s.seq_em)
									o = push(o, mk(EV_ABORT, '0, '0, 1'b0, s));
								s = clr(s);
							end
							if (b < 8'h20)
								o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
							else if (b == 8'h5B) begin
								s = clr(s);
								s.ps = S_CSIE;
							end else if (b == 8'h5D) begin
								s = clr(s);
								s.ps = S_OSC;
							end else if (b == 8'h50) begin
								s = clr(s);
								s.ps = S_DCSE;
							end else if (b == 8'h58 || b == 8'h5E || b == 8'h5F)
								s.ps = S_SOS;
							else if (b <= 8'h2F) begin
								s = clr(s);
								s = coll(s, b);
								s.ps = S_ESCI;
							end else if (b <= 8'h7E) begin
								o = push(o, mk(EV_ESC, {13'd0, b}, '0, 1'b0, s));
								s = clr(s);
								s.ps = S_GROUND;
							end
						end
					end
				end
				S_ESCI: begin
					if (b < 8'h20)
						o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
					else if (b <= 8'h2F)
						s = coll(s, b);
					else if (b <= 8'h7E) begin
						o = push(o, mk(EV_ESC, {13'd0, b}, '0, 1'b0, s));
						s = clr(s);
						s.ps = S_GROUND;
					end
				end
				S_CSIE, S_CSIP, S_CSII, S_DCSE, S_DCSP, S_DCSI: begin
					if (b < 8'h20) begin
						if (s.ps == S_CSIE || s.ps == S_CSIP || s.ps == S_CSII)
							o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
					end else if ((s.ps != S_CSII && s.ps != S_DCSI) && (is_dig || b == 8'h3B
							|| (b == 8'h3A && s.ps == S_CSIP))) begin
						if (is_dig) begin
							s.acc = dig(s.acc_st ? s.acc : 16'd0, b);
							s.acc_st = 1'b1;
						end else begin
							o = push(o, mk(EV_PARAM, {13'd0, b}, pv, s.sub, s));
							s.seq_em = 1'b1;
							s.acc_st = 1'b0;
							s.acc = '0;
							s.sub = (b == 8'h3A);
						end
						if (s.ps == S_CSIE)
							s.ps = S_CSIP;
						else if (s.ps == S_DCSE)
							s.ps = S_DCSP;
					end else if (b <= 8'h2F) begin
						s = coll(s, b);
						s.ps = (s.ps == S_CSIE || s.ps == S_CSIP || s.ps == S_CSII) ? S_CSII
							: S_DCSI;
					end else if (b >= 8'h40 && b <= 8'h7E) begin
						if (s.acc_st || s.sub) begin
							o = push(o, mk(EV_PARAM, {13'd0, b}, pv, s.sub, s));
							s.seq_em = 1'b1;
							s.acc_st = 1'b0;
							s.acc = '0;
						end
						if (s.ps == S_CSIE || s.ps == S_CSIP || s.ps == S_CSII) begin
							o = push(o, mk(EV_CSI, {13'd0, b}, '0, 1'b0, s));
							s = clr(s);
							s.ps = S_GROUND;
						end else begin
							o = push(o, mk(EV_DCS_HOOK, {13'd0, b}, '0, 1'b0, s));
							s.dcs_final = b;
							s.seq_em = 1'b1;
							s.slen = '0;
							s.ps = S_DCSPASS;
						end
					end else if (b >= 8'h3C && b <= 8'h3F
							&& (s.ps == S_CSIE || s.ps == S_DCSE)) begin
						s = coll(s, b);
						s.ps = (s.ps == S_CSIE) ? S_CSIP : S_DCSP;
					end else if (b >= 8'h30 && b <= 8'h3F && (s.ps == S_CSII || s.ps == S_DCSI
							|| b >= 8'h3C)) begin
						// colon in csi entry, dcs entry or dcs params matches no branch and is left untouched
						if (s.seq_em)
							o = push(o, mk(EV_ABORT, '0, '0, 1'b0, s));
						s = clr(s);
						s.ps = (st.ps == S_CSIP || st.ps == S_CSII) ? S_CSIX : S_DCSX;
					end
				end
				S_CSIX: begin
					if (b < 8'h20)
						o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
					else if (b >= 8'h40 && b <= 8'h7E) begin
						s = clr(s);
						s.ps = S_GROUND;
					end
				end
				S_OSC, S_DCSPASS: begin
					if ((s.ps == S_OSC && (b == B_BEL || b == B_ST))
							|| (s.ps == S_DCSPASS && b == B_ST)) begin
						if (s.ps == S_OSC)
							o = push(o, mk(EV_OSC_END, {13'd0, b}, '0, 1'b0, s));
						else
							o = push(o, mk(EV_DCS_END, {13'd0, s.dcs_final}, '0, 1'b0, s));
						s = clr(s);
						s.ps = S_GROUND;
					end else if (s.ps == S_OSC && !s.osc_done && is_dig) begin
						s.osc = {1'b0, dig(s.osc[16] ? 16'd0 : s.osc[15:0], b)};
					end else if (s.ps == S_OSC && !s.osc_done && b == 8'h3B) begin
						s.osc_done = 1'b1;
					end else if ((s.ps == S_OSC && (!s.osc_done || b >= 8'h20 || b == 8'h09))
							|| (s.ps == S_DCSPASS && b >= 8'h20 && b != B_DEL)) begin
						s.osc_done = s.osc_done | (s.ps == S_OSC);
						if (s.slen >= cap) begin
							if (s.seq_em)
								o = push(o, mk(EV_ABORT, '0, '0, 1'b0, s));
							s = clr(s);
							s.ps = S_GROUND;
						end else begin
							o = push(o, mk((s.ps == S_OSC) ? EV_OSC_BYTE : EV_DCS_BYTE,
								{13'd0, b}, '0, 1'b0, s));
							s.slen = s.slen + 21'd1;
							s.seq_em = 1'b1;
						end
					end
				end
				S_DCSX, S_SOS: begin
					if (b == B_ST) begin
						s = clr(s);
						s.ps = S_GROUND;
					end
				end
				default: begin
					s.ps = S_GROUND;
					if (b < 8'h20)
						o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
					else if (b == B_DEL) begin
					end else if (b < 8'h7F)
						o = push(o, mk(EV_PRINT, {13'd0, b}, '0, 1'b0, s));
					else if (b <= 8'h9F) begin
						if (b == B_CSI) begin
							s = clr(s);
							s.ps = S_CSIE;
						end else if (b == B_OSC) begin
							s = clr(s);
							s.ps = S_OSC;
						end else if (b == B_DCS) begin
							s = clr(s);
							s.ps = S_DCSE;
						end else
							o = push(o, mk(EV_EXECUTE, {13'd0, b}, '0, 1'b0, s));
					end else if (b < 8'hC0) begin
					end else if (b < 8'hE0) begin
						s.u8acc = {16'd0, b[4:0]};
						s.u8left = 2'd1;
						s.ps = S_UTF8;
					end else if (b < 8'hF0) begin
						s.u8acc = {17'd0, b[3:0]};
						s.u8left = 2'd2;
						s.ps = S_UTF8;
					end else if (b < 8'hF8) begin
						s.u8acc = {18'd0, b[2:0]};
						s.u8left = 2'd3;
						s.ps = S_UTF8;
					end
				end
			endcase
		end

		if (o.n == 2'd1)
			o.r0.last = 1'b1;
		else if (o.n == 2'd2)
			o.r1.last = 1'b1;
	end

	assign nxt  = s;
	assign res0 = o.r0;
	assign res1 = o.r1;
	assign n    = o.n;

endmodule

FILE: design/vt_escape_sequence_parser.sv
// channel | direction | handshake             | payload
// in      | sink      | in_valid / in_ready   | in_byte
// out     | source    | out_valid / out_ready | event_res .. last_of_run
// cfg     | sink      | cfg_valid / cfg_ready | cfg_data (string_cap)
// one byte is taken per cycle while the result queue has room for two results
// each byte updates the parser state in the cycle it is taken; its results
// enter a four-deep queue and leave one per cycle while out_ready is high;
// input is held off while three or more results are waiting
// reset puts the parser in ground state and string_cap at 1048576
module vt_escape_sequence_parser #(
	parameter int MAX_INTERMEDIATES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic [20:0] char_value,
	output logic signed [16:0] param_value,
	output logic        param_is_sub,
	output logic [31:0] inter_bytes,
	output logic [2:0]  inter_count,
	output logic signed [16:0] osc_code,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data
);
	import vtp_pkg::*;

	localparam int InterCap = (MAX_INTERMEDIATES < 4) ? MAX_INTERMEDIATES : 4;
	localparam vtp_state_t StateRst = '{ps: S_GROUND, tp: TP_NONE, osc: NONE_17,
		default: '0};

	vtp_state_t  state_q, state_nxt;
	vtp_res_t    res0, res1;
	logic [1:0]  nres;
	logic [20:0] cap_q;
	vtp_res_t    fifo_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        acc_in, acc_out;

	vtp_step #(.InterCap(InterCap)) u_step (
		.st   (state_q),
		.b    (in_byte),
		.cap  (cap_q),
		.nxt  (state_nxt),
		.res0 (res0),
		.res1 (res1),
		.n    (nres)
	);

	assign in_ready  = (cnt_q <= 3'd2);
	assign cfg_ready = 1'b1;
	assign out_valid = (cnt_q != 3'd0);
	assign acc_in    = in_valid && in_ready;
	assign acc_out   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateRst;
			cap_q <= STR_CAP_RST;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
			if (acc_in) begin
				state_q <= state_nxt;
				wr_q <= wr_q + nres;
			end
			if (acc_out)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (acc_in ? {1'b0, nres} : 3'd0) - {2'd0, acc_out};
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (nres != 2'd0)
				fifo_q[wr_q] <= res0;
			if (nres == 2'd2)
				fifo_q[wr_q + 2'd1] <= res1;
		end
	end

	assign event_res    = fifo_q[rd_q].ev;
	assign char_value   = fifo_q[rd_q].ch;
	assign param_value  = fifo_q[rd_q].pv;
	assign param_is_sub = fifo_q[rd_q].sub;
	assign inter_bytes  = fifo_q[rd_q].inter;
	assign inter_count  = fifo_q[rd_q].cnt;
	assign osc_code     = fifo_q[rd_q].osc;
	assign last_of_run  = fifo_q[rd_q].last;

endmodule

FILE: design/vtp_checker.sv
module vtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  event_res,
	input logic [16:0] param_value,
	input logic        param_is_sub,
	input logic [2:0]  inter_count,
	input logic [16:0] osc_code
);
	import vtp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_ABORT)
		else $error("bad event code");

	a_param: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PARAM |-> param_value == '0 && !param_is_sub)
		else $error("param fields on non-param event");

	a_inter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_ESC && event_res != EV_CSI
		&& event_res != EV_DCS_HOOK |-> inter_count == '0)
		else $error("intermediates on wrong event");

	a_osc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_OSC_BYTE && event_res != EV_OSC_END |-> osc_code == '0)
		else $error("osc code on wrong event");

endmodule

bind vt_escape_sequence_parser vtp_checker u_vtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_res    (event_res),
	.param_value  (param_value),
	.param_is_sub (param_is_sub),
	.inter_count  (inter_count),
	.osc_code     (osc_code)
);
